[rtl/gps_pkg.sv]
`timescale 1ns / 1ps

package gps_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_CHECK = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    localparam int NUM_STAGES    = 8;
    localparam int NUM_ACTUATORS = 4;
    localparam int ROM_ACTS      = 4;
    localparam int ROM_STAGES    = 8;
    localparam int QUEUE_DEPTH   = 2;

    // Pressures in units of 1/16
    localparam logic [7:0] P_ZERO = 8'd0;   // 0.0
    localparam logic [7:0] P_LOW  = 8'd48;  // 3.0
    localparam logic [7:0] P_MID  = 8'd72;  // 4.5
    localparam logic [7:0] P_HIGH = 8'd80;  // 5.0

    // Motion ids
    localparam logic [1:0] MOTION_NONE     = 2'd0;
    localparam logic [1:0] MOTION_STAND    = 2'd1;
    localparam logic [1:0] MOTION_WALK     = 2'd2;
    localparam logic [1:0] MOTION_WALK_ALT = 2'd3;

    // Register byte address width; its top bit selects beyond the register list
    localparam int CFG_ADDR_W = 3;

    typedef logic [7:0] t_row [ROM_STAGES];
    typedef t_row t_pattern [ROM_ACTS];

    localparam t_pattern ROM_STAND = '{
        '{P_LOW, P_LOW, P_LOW, P_LOW, P_MID, P_MID, P_MID, P_MID},
        '{P_ZERO, P_LOW, P_LOW, P_LOW, P_LOW, P_MID, P_MID, P_MID},
        '{P_ZERO, P_ZERO, P_LOW, P_LOW, P_LOW, P_LOW, P_MID, P_MID},
        '{P_ZERO, P_ZERO, P_ZERO, P_LOW, P_LOW, P_LOW, P_LOW, P_MID}
    };

    localparam t_pattern ROM_STEP = '{
        '{P_ZERO, P_ZERO, P_MID, P_MID, P_MID, P_MID, P_MID, P_MID},
        '{P_MID, P_MID, P_MID, P_MID, P_ZERO, P_ZERO, P_MID, P_MID},
        '{P_MID, P_LOW, P_LOW, P_MID, P_MID, P_MID, P_MID, P_MID},
        '{P_MID, P_MID, P_MID, P_MID, P_MID, P_LOW, P_LOW, P_MID}
    };

    localparam t_pattern ROM_STEP2 = '{
        '{P_ZERO, P_MID, P_LOW, P_HIGH, P_LOW, P_MID, P_ZERO, P_LOW},
        '{P_ZERO, P_ZERO, P_ZERO, P_ZERO, P_ZERO, P_ZERO, P_ZERO, P_ZERO},
        '{P_ZERO, P_ZERO, P_ZERO, P_ZERO, P_ZERO, P_ZERO, P_ZERO, P_ZERO},
        '{P_ZERO, P_ZERO, P_ZERO, P_ZERO, P_ZERO, P_ZERO, P_ZERO, P_ZERO}
    };

    function automatic logic [7:0] rom_pressure(input logic [1:0] motion,
                                                input logic [1:0] act,
                                                input logic [2:0] stg);
        logic [7:0] p;
        p = P_ZERO;
        unique case (motion)
            MOTION_STAND:    p = ROM_STAND[act][stg];
            MOTION_WALK:     p = ROM_STEP[act][stg];
            MOTION_WALK_ALT: p = ROM_STEP2[act][stg];
            default:         p = P_ZERO;
        endcase
        return p;
    endfunction

    // One classified input: which actuators to command and the status after it
    typedef struct packed {
        logic [ROM_ACTS-1:0]      mask;
        logic [ROM_ACTS-1:0][7:0] pres;
        logic                     busy;
        logic [2:0]               stage;
    } t_job;

endpackage

[rtl/gps_front.sv]
`timescale 1ns / 1ps

module gps_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_op,
    input  logic [1:0]        i_motion,
    input  logic [1:0]        i_actuator,
    input  logic [3:0]        i_cal_mask,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output gps_pkg::t_job     o_job
);

    logic [1:0] r_motion;
    logic [2:0] r_stage;
    logic [3:0] r_flags;
    logic [1:0] n_motion;
    logic [2:0] n_stage;
    logic [3:0] n_flags;
    logic       enter;
    logic [3:0] cmd;
    logic [3:0][7:0] pres;
    logic [3:0] next_stage;

    assign o_stall = i_full;
    assign o_push  = i_valid & ~i_full;

    // Classify the word and work out the state it leaves
    always_comb begin
        n_motion   = r_motion;
        n_stage    = r_stage;
        n_flags    = r_flags;
        enter      = 1'b0;
        next_stage = {1'b0, r_stage} + 4'd1;
        unique case (gps_pkg::t_op'(i_op))
            gps_pkg::OP_BEGIN: begin
                n_motion = i_motion;
                n_stage  = 3'd0;
                n_flags  = 4'd0;
                enter    = (i_motion != gps_pkg::MOTION_NONE);
            end
            gps_pkg::OP_CHECK: begin
                n_flags = r_flags & ~(4'b0001 << i_actuator);
            end
            gps_pkg::OP_TICK: begin
                if (r_motion != gps_pkg::MOTION_NONE && r_flags == 4'd0) begin
                    if (next_stage < 4'(gps_pkg::NUM_STAGES)) begin
                        n_stage = next_stage[2:0];
                        enter   = 1'b1;
                    end else begin
                        n_stage  = 3'd0;
                        n_motion = gps_pkg::MOTION_NONE;
                    end
                end
            end
            default: ;
        endcase

        // Stage entry: command each calibrated actuator whose pressure moves, or every one at stage 0
        for (int i = 0; i < gps_pkg::ROM_ACTS; i++) begin
            pres[i] = gps_pkg::rom_pressure(n_motion, 2'(i), n_stage);
            cmd[i]  = enter && i_cal_mask[i] && (i < gps_pkg::NUM_ACTUATORS) &&
                      ((n_stage == 3'd0) ||
                       (pres[i] != gps_pkg::rom_pressure(n_motion, 2'(i),
                                                         n_stage - 3'd1)));
        end
        n_flags = n_flags | cmd;
    end

    always_comb begin
        o_job.mask  = cmd;
        o_job.pres  = pres;
        o_job.busy  = (n_motion != gps_pkg::MOTION_NONE);
        o_job.stage = n_stage;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion <= gps_pkg::MOTION_NONE;
            r_stage  <= 3'd0;
            r_flags  <= 4'd0;
        end else if (o_push) begin
            r_motion <= n_motion;
            r_stage  <= n_stage;
            r_flags  <= n_flags;
        end
    end

endmodule

[rtl/gps_queue.sv]
`timescale 1ns / 1ps

module gps_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gps_pkg::t_job i_job,
    input  logic          i_pop,
    output gps_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PTR_W = $clog2(gps_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(gps_pkg::QUEUE_DEPTH + 1);

    gps_pkg::t_job     r_slot [gps_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(gps_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/gps_back.sv]
`timescale 1ns / 1ps

module gps_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  gps_pkg::t_job i_job,
    output logic          o_pop,
    input  logic          i_stall,
    output logic          o_valid,
    output logic          o_set_valid,
    output logic [1:0]    o_target_actuator,
    output logic [7:0]    o_target_pressure,
    output logic          o_busy_res,
    output logic [2:0]    o_stage_now,
    output logic          o_last
);

    logic            r_cur_valid;
    logic [3:0]      r_rem;
    logic [3:0][7:0] r_pres;
    logic            r_busy;
    logic [2:0]      r_stage;
    logic            r_status_only;
    logic            r_out_valid;
    logic            out_free;
    logic            emit;
    logic            done;
    logic [1:0]      sel;
    logic [3:0]      rem_after;

    assign out_free = ~r_out_valid | ~i_stall;
    assign emit     = r_cur_valid & out_free;

    // Lowest pending actuator goes first
    always_comb begin
        sel = 2'd0;
        for (int i = gps_pkg::ROM_ACTS - 1; i >= 0; i--) begin
            if (r_rem[i]) begin
                sel = 2'(i);
            end
        end
        rem_after = r_rem & ~(4'b0001 << sel);
        done      = r_status_only | (rem_after == 4'd0);
    end

    assign o_pop   = ~i_empty & (~r_cur_valid | (emit & done));
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_cur_valid <= 1'b1;
            end else if (emit && done) begin
                r_cur_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_set_valid       <= ~r_status_only;
            o_target_actuator <= r_status_only ? 2'd0 : sel;
            o_target_pressure <= r_status_only ? 8'd0 : r_pres[sel];
            o_busy_res        <= r_busy;
            o_stage_now       <= r_stage;
            o_last            <= done;
        end
        if (o_pop) begin
            r_rem         <= i_job.mask;
            r_status_only <= (i_job.mask == 4'd0);
            r_pres        <= i_job.pres;
            r_busy        <= i_job.busy;
            r_stage       <= i_job.stage;
        end else if (emit) begin
            r_rem <= rem_after;
        end
    end

endmodule

[rtl/gait_pattern_sequencer_core.sv]
`timescale 1ns / 1ps

// Gait pattern sequencer: steps four pneumatic actuators through ROM patterns.
// Input channel: i_valid / o_stall carry one word (op, motion, actuator);
//   a word is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one result word per command, or one
//   status word when a word issues no command; o_last marks the final one.
// The front classifies each word at once and updates motion, stage and flags;
// a two-entry queue parts it from the back, which issues the commands.
// A taken word passes through a queue slot and the back's job registers to the output register.
// Throughput: one result per cycle while i_stall is low; a word yields 1 to 4
//   results, as set by the number of commands the back must serialise on the single output register.
// Stall: while i_stall is high the output word holds; the back then holds, the
//   queue fills and o_stall rises once both slots are taken.
// Reset (synchronous, active low): no motion, stage and flags zero, queue and
//   output empty, calibrated_mask zero. No clearing pass is needed.
// Configuration: calibrated_mask at byte address 0 over the APB port; write it
//   only while the block is idle.
module gait_pattern_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [1:0]  i_motion,
    input  logic [1:0]  i_actuator,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_set_valid,
    output logic [1:0]  o_target_actuator,
    output logic [7:0]  o_target_pressure,
    output logic        o_busy_res,
    output logic [2:0]  o_stage_now,
    output logic        o_last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [gps_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic          cal_sel;
    logic [3:0]    r_cal;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    gps_pkg::t_job front_job;
    gps_pkg::t_job queue_job;

    // Only the first register exists; anything above it is dropped
    assign cal_sel = ~paddr[gps_pkg::CFG_ADDR_W-1];
    assign pready  = 1'b1;
    assign prdata  = cal_sel ? {28'd0, r_cal} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= 4'd0;
        end else if (psel && penable && pwrite && pready && cal_sel) begin
            r_cal <= pwdata[3:0];
        end
    end

    // Front: take and classify words, keep the motion state
    gps_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_op       (i_op),
        .i_motion   (i_motion),
        .i_actuator (i_actuator),
        .i_cal_mask (r_cal),
        .i_full     (full),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_job      (front_job)
    );

    // Short queue between the two halves
    gps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_full  (full),
        .o_empty (empty)
    );

    // Back: serialise the commands of each job onto the output register
    gps_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (empty),
        .i_job             (queue_job),
        .o_pop             (pop),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_set_valid       (o_set_valid),
        .o_target_actuator (o_target_actuator),
        .o_target_pressure (o_target_pressure),
        .o_busy_res        (o_busy_res),
        .o_stage_now       (o_stage_now),
        .o_last            (o_last)
    );

endmodule
